/* sv/edge_pixel_graph_builder_defines.svh */
// assertion macros for the edge pixel graph builder
// no dependencies; included by the top level
`ifndef EDGE_PIXEL_GRAPH_BUILDER_DEFINES_SVH
`define EDGE_PIXEL_GRAPH_BUILDER_DEFINES_SVH
`ifndef SYNTHESIS
`define EPGB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("edge pixel graph builder: check failed");
`define EPGB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("edge pixel graph builder: check failed");
`else
`define EPGB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define EPGB_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/epgb_pkg.sv */
// shared types and constants for the edge pixel graph builder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package epgb_pkg;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DIM_W          = 13;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_DATA_W     = 152;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_THRESH = 3'd2;
  localparam logic [2:0] REG_MODE   = 3'd3;
  localparam logic [2:0] REG_LABEL  = 3'd4;

  typedef enum logic [1:0] {
    KIND_NODE    = 2'd0,
    KIND_EDGE    = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  typedef struct packed {
    logic [10:0] frame_width;
    logic [10:0] frame_height;
    logic [7:0]  edge_threshold;
    logic        eight_mode;
    logic [15:0] graph_label;
  } cfg_t;

  typedef struct packed {
    logic [7:0] top;
    logic [7:0] mid;
    logic [7:0] edge_v;
  } line_t;

  typedef struct packed {
    logic        valid;
    logic [20:0] num;
  } node_ent_t;

  // mask: node, left pair, up pair, up-left pair, up-right pair, summary
  typedef struct packed {
    logic [9:0]        mask;
    logic [9:0]        row;
    logic [9:0]        col;
    logic [7:0]        intensity;
    logic signed [10:0] gx;
    logic signed [10:0] gy;
    logic [20:0]       id;
    logic [20:0]       left_num;
    logic [20:0]       up_num;
    logic [20:0]       ul_num;
    logic [20:0]       ur_num;
    logic [20:0]       node_total;
    logic [23:0]       edge_total;
    logic [15:0]       label;
  } job_t;
endpackage
`default_nettype wire

/* sv/epgb_cfg.sv */
// apb configuration registers
// depends on epgb_pkg
`timescale 1ns / 1ps
`default_nettype none
module epgb_cfg (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [4:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output epgb_pkg::cfg_t    cfg_o
);
  epgb_pkg::cfg_t cfg_r;
  logic           wr;
  logic [2:0]     idx;

  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;
  assign cfg_o      = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width    <= 11'd1024;
      cfg_r.frame_height   <= 11'd1024;
      cfg_r.edge_threshold <= 8'd25;
      cfg_r.eight_mode     <= 1'b0;
      cfg_r.graph_label    <= 16'd0;
    end else if (wr) begin
      unique case (idx)
        epgb_pkg::REG_WIDTH:  cfg_r.frame_width    <= cfg_pwdata[10:0];
        epgb_pkg::REG_HEIGHT: cfg_r.frame_height   <= cfg_pwdata[10:0];
        epgb_pkg::REG_THRESH: cfg_r.edge_threshold <= cfg_pwdata[7:0];
        epgb_pkg::REG_MODE:   cfg_r.eight_mode     <= cfg_pwdata[0];
        epgb_pkg::REG_LABEL:  cfg_r.graph_label    <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      epgb_pkg::REG_WIDTH:  cfg_prdata = {21'd0, cfg_r.frame_width};
      epgb_pkg::REG_HEIGHT: cfg_prdata = {21'd0, cfg_r.frame_height};
      epgb_pkg::REG_THRESH: cfg_prdata = {24'd0, cfg_r.edge_threshold};
      epgb_pkg::REG_MODE:   cfg_prdata = {31'd0, cfg_r.eight_mode};
      epgb_pkg::REG_LABEL:  cfg_prdata = {16'd0, cfg_r.graph_label};
      default:              cfg_prdata = 32'd0;
    endcase
  end
endmodule
`default_nettype wire

/* sv/epgb_front.sv */
// front end: pixel accept, line stores, window, node classification
// depends on epgb_pkg; produces job_t entries for the queue
`timescale 1ns / 1ps
`default_nettype none
module epgb_front #(
  parameter int MAX_WIDTH  = epgb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = epgb_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  epgb_pkg::cfg_t    cfg_i,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [15:0]  in_tdata,
  output logic              busy_o,
  output logic              push_o,
  output epgb_pkg::job_t    job_o
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int DW = epgb_pkg::DIM_W;

  epgb_pkg::line_t     line_mem [MAX_WIDTH];
  epgb_pkg::node_ent_t node_mem [MAX_WIDTH];

  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [DW-1:0] w_lim, h_lim, wf, hf, c_ext, r_ext;
  logic          accept, row_end, frame_end, interior_s0, ur_ok_s0;

  logic          p1_valid_r;
  logic [7:0]    grey_p1_r, edge_p1_r;
  logic [CW-1:0] c_p1_r;
  logic [RW-1:0] r_p1_r;
  logic          interior_p1_r, ur_ok_p1_r, eof_p1_r;
  epgb_pkg::line_t     line_rd_r;
  epgb_pkg::node_ent_t node_rd_r;

  logic [7:0]    win_r [3][3];
  logic [7:0]    edge_dly_r;
  epgb_pkg::node_ent_t nn_prev_r, ul_r, left_r;
  logic [20:0]   node_cnt_r, node_cnt_nxt;
  logic [23:0]   edge_cnt_r, edge_cnt_nxt;

  logic          is_node, ri_ge2, ci_ge2;
  logic          has_left, has_up, has_ul, has_ur;
  logic [2:0]    pairs;
  logic [10:0]   sum_l, sum_r, sum_t, sum_b;
  logic [CW-1:0] ci;
  logic [RW-1:0] ri;

  assign accept = in_tvalid && in_tready;
  assign busy_o = p1_valid_r;

  always_comb begin
    wf    = DW'(cfg_i.frame_width);
    hf    = DW'(cfg_i.frame_height);
    w_lim = (wf < DW'(3)) ? DW'(3) : ((wf > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : wf);
    h_lim = (hf < DW'(3)) ? DW'(3) : ((hf > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : hf);
    c_ext = DW'(col_r);
    r_ext = DW'(row_r);
    row_end     = (c_ext + DW'(1)) >= w_lim;
    frame_end   = row_end && ((r_ext + DW'(1)) >= h_lim);
    interior_s0 = (r_ext >= DW'(2)) && (c_ext >= DW'(2)) &&
                  (r_ext <= h_lim - DW'(1)) && (c_ext <= w_lim - DW'(1));
    ur_ok_s0    = (c_ext + DW'(2)) <= w_lim;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      p1_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= accept;
      if (accept) begin
        if (row_end) begin
          col_r <= '0;
          row_r <= frame_end ? '0 : row_r + RW'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      grey_p1_r     <= in_tdata[7:0];
      edge_p1_r     <= in_tdata[15:8];
      c_p1_r        <= col_r;
      r_p1_r        <= row_r;
      interior_p1_r <= interior_s0;
      ur_ok_p1_r    <= ur_ok_s0;
      eof_p1_r      <= frame_end;
      line_rd_r     <= line_mem[col_r];
      node_rd_r     <= node_mem[col_r];
    end
    if (p1_valid_r) begin
      line_mem[c_p1_r] <= '{top: line_rd_r.mid, mid: grey_p1_r, edge_v: edge_p1_r};
      if (interior_p1_r) begin
        node_mem[ci] <= '{valid: is_node, num: node_cnt_r};
      end
    end
  end

  always_comb begin
    ci      = c_p1_r - CW'(1);
    ri      = r_p1_r - RW'(1);
    is_node = interior_p1_r && (edge_dly_r > cfg_i.edge_threshold);
    ri_ge2  = r_p1_r >= RW'(3);
    ci_ge2  = c_p1_r >= CW'(3);
    has_left = is_node && ci_ge2 && left_r.valid;
    has_up   = is_node && ri_ge2 && nn_prev_r.valid;
    has_ul   = is_node && cfg_i.eight_mode && ri_ge2 && ci_ge2 && ul_r.valid;
    has_ur   = is_node && cfg_i.eight_mode && ri_ge2 && ur_ok_p1_r && node_rd_r.valid;
    pairs    = 3'(has_left) + 3'(has_up) + 3'(has_ul) + 3'(has_ur);
    node_cnt_nxt = node_cnt_r + 21'(is_node);
    edge_cnt_nxt = edge_cnt_r + {20'd0, pairs, 1'b0};
    sum_l = 11'(win_r[0][1]) + 11'(win_r[1][1]) + 11'(win_r[2][1]);
    sum_r = 11'(line_rd_r.top) + 11'(line_rd_r.mid) + 11'(grey_p1_r);
    sum_t = 11'(win_r[0][1]) + 11'(win_r[0][2]) + 11'(line_rd_r.top);
    sum_b = 11'(win_r[2][1]) + 11'(win_r[2][2]) + 11'(grey_p1_r);

    job_o.mask       = {eof_p1_r, has_ur, has_ur, has_ul, has_ul,
                        has_up, has_up, has_left, has_left, is_node};
    job_o.row        = 10'(ri);
    job_o.col        = 10'(ci);
    job_o.intensity  = win_r[1][2];
    job_o.gx         = $signed(sum_l - sum_r);
    job_o.gy         = $signed(sum_t - sum_b);
    job_o.id         = node_cnt_r;
    job_o.left_num   = left_r.num;
    job_o.up_num     = nn_prev_r.num;
    job_o.ul_num     = ul_r.num;
    job_o.ur_num     = node_rd_r.num;
    job_o.node_total = node_cnt_nxt;
    job_o.edge_total = edge_cnt_nxt;
    job_o.label      = cfg_i.graph_label;
    push_o           = p1_valid_r && (job_o.mask != 10'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= 8'd0;
        end
      end
      edge_dly_r <= 8'd0;
      nn_prev_r  <= '0;
      ul_r       <= '0;
      left_r     <= '0;
      node_cnt_r <= '0;
      edge_cnt_r <= '0;
    end else if (p1_valid_r) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= line_rd_r.top;
      win_r[1][2] <= line_rd_r.mid;
      win_r[2][2] <= grey_p1_r;
      edge_dly_r  <= line_rd_r.edge_v;
      nn_prev_r   <= node_rd_r;
      if (interior_p1_r) begin
        ul_r   <= nn_prev_r;
        left_r <= '{valid: is_node, num: node_cnt_r};
      end
      if (eof_p1_r) begin
        node_cnt_r <= '0;
        edge_cnt_r <= '0;
      end else begin
        node_cnt_r <= node_cnt_nxt;
        edge_cnt_r <= edge_cnt_nxt;
      end
    end
  end
endmodule
`default_nettype wire

/* sv/epgb_queue.sv */
// small job queue between front and back
// depends on epgb_pkg
`timescale 1ns / 1ps
`default_nettype none
module epgb_queue (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push_i,
  input  epgb_pkg::job_t                   job_i,
  input  wire logic                        pop_i,
  output logic                             valid_o,
  output epgb_pkg::job_t                   job_o,
  output logic [epgb_pkg::QCNT_W-1:0]      count_o
);
  localparam int D  = epgb_pkg::QUEUE_DEPTH;
  localparam int PW = $clog2(D);

  epgb_pkg::job_t            q_r [D];
  logic [PW-1:0]             wp_r, rp_r;
  logic [epgb_pkg::QCNT_W-1:0] cnt_r;

  assign valid_o = cnt_r != '0;
  assign job_o   = q_r[rp_r];
  assign count_o = cnt_r;

  always_ff @(posedge clk) begin
    if (push_i) q_r[wp_r] <= job_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_i) wp_r <= (wp_r == PW'(D - 1)) ? '0 : wp_r + PW'(1);
      if (pop_i)  rp_r <= (rp_r == PW'(D - 1)) ? '0 : rp_r + PW'(1);
      cnt_r <= cnt_r + epgb_pkg::QCNT_W'(push_i) - epgb_pkg::QCNT_W'(pop_i);
    end
  end
endmodule
`default_nettype wire

/* sv/epgb_back.sv */
// back end: walks the records of one job and drives the output register
// depends on epgb_pkg
`timescale 1ns / 1ps
`default_nettype none
module epgb_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            valid_i,
  input  epgb_pkg::job_t                       job_i,
  output logic                                 pop_o,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [epgb_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [1:0]                           out_tuser,
  output logic                                 out_tlast
);
  logic [9:0]  done_r, pend, sel;
  logic        load, last;
  logic        valid_r, last_r;
  epgb_pkg::kind_t kind, kind_r;
  logic [epgb_pkg::OUT_DATA_W-1:0] data, data_r;
  logic [20:0] other, from_n, to_n;

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

  always_comb begin
    pend  = job_i.mask & ~done_r;
    sel   = pend & (~pend + 10'd1);
    last  = (pend & ~sel) == 10'd0;
    load  = valid_i && (!valid_r || out_tready);
    pop_o = load && last;
    other = job_i.left_num;
    priority if (sel[1] || sel[2]) other = job_i.left_num;
    else if (sel[3] || sel[4])     other = job_i.up_num;
    else if (sel[5] || sel[6])     other = job_i.ul_num;
    else                           other = job_i.ur_num;
    if (sel[1] || sel[3] || sel[5] || sel[7]) begin
      from_n = other;
      to_n   = job_i.id;
    end else begin
      from_n = job_i.id;
      to_n   = other;
    end
    priority if (sel[0]) begin
      kind = epgb_pkg::KIND_NODE;
      data = {1'b0, 16'd0, 24'd0, 21'd0, 20'd0, 20'd0, job_i.gy, job_i.gx,
              job_i.intensity, job_i.col, job_i.row};
    end else if (sel[9]) begin
      kind = epgb_pkg::KIND_SUMMARY;
      data = {1'b0, job_i.label, job_i.edge_total, job_i.node_total, 20'd0, 20'd0,
              11'd0, 11'd0, 8'd0, 10'd0, 10'd0};
    end else begin
      kind = epgb_pkg::KIND_EDGE;
      data = {1'b0, 16'd0, 24'd0, 21'd0, to_n[19:0], from_n[19:0],
              11'd0, 11'd0, 8'd0, 10'd0, 10'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      done_r  <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        done_r  <= last ? '0 : (done_r | sel);
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data;
      kind_r <= kind;
      last_r <= last;
    end
  end
endmodule
`default_nettype wire

/* sv/edge_pixel_graph_builder.sv */
// edge pixel graph builder, top level
// depends on epgb_pkg, epgb_cfg, epgb_front, epgb_queue, epgb_back and the defines header
//
// in_*: one pixel item per handshake, tdata = grey (7:0), edge (15:8), raster order.
// out_*: one record per handshake, tuser = record kind (node, edge, summary),
//   tlast on the final record caused by a pixel. a node pixel yields its node
//   record, then a pair of directed edge records per linked neighbour; the last
//   pixel of a frame also yields the summary record.
// cfg_*: apb register port, write only while the stream is idle.
// a pixel is accepted every cycle while the job queue has room; a pixel is
//   judged in the cycle after acceptance (line store read), and its first record
//   passes through the job queue into the output register. the back end then
//   emits one record per cycle while the receiver is ready; a node yields 1 to 9
//   records (up to 10 with the summary); the output handshake sets the sustained rate.
// reset clears positions, counters, window and queue; the line stores need no
//   clearing. when the receiver stalls, the output register holds its record,
//   the queue fills and in_tready drops after at most four pending jobs.
`timescale 1ns / 1ps
`default_nettype none
`include "edge_pixel_graph_builder_defines.svh"
module edge_pixel_graph_builder #(
  parameter int MAX_WIDTH  = epgb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = epgb_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [15:0]  in_tdata,   // grey_pixel, edge_pixel
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // pixel_row, pixel_col, intensity, grad_x, grad_y, edge_from, edge_to,
  // node_total, edge_total, label_out, one pad bit
  output logic [epgb_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]        out_tuser,  // record_kind
  output logic              out_tlast,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [4:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  epgb_pkg::cfg_t cfg;
  epgb_pkg::job_t job_in, job_head;
  logic           busy, q_push, q_pop, q_valid;
  logic [epgb_pkg::QCNT_W-1:0] q_count;

  assign in_tready = (epgb_pkg::QCNT_W'(q_count) + epgb_pkg::QCNT_W'(busy))
                     < epgb_pkg::QCNT_W'(epgb_pkg::QUEUE_DEPTH);

  epgb_cfg u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready, .cfg_o(cfg)
  );

  epgb_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst_n, .cfg_i(cfg), .in_tvalid, .in_tready, .in_tdata,
    .busy_o(busy), .push_o(q_push), .job_o(job_in)
  );

  epgb_queue u_queue (
    .clk, .rst_n, .push_i(q_push), .job_i(job_in), .pop_i(q_pop),
    .valid_o(q_valid), .job_o(job_head), .count_o(q_count)
  );

  epgb_back u_back (
    .clk, .rst_n, .valid_i(q_valid), .job_i(job_head), .pop_o(q_pop),
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

  `EPGB_ASSERT_IMP(a_queue_no_overflow, clk, rst_n, q_push && !q_pop, q_count < epgb_pkg::QCNT_W'(epgb_pkg::QUEUE_DEPTH))
  `EPGB_ASSERT_IMP(a_summary_is_last, clk, rst_n, out_tvalid && out_tuser == epgb_pkg::KIND_SUMMARY, out_tlast)
  `EPGB_ASSERT_NXT(a_accept_reaches_front, clk, rst_n, in_tvalid && in_tready, busy)
endmodule
`default_nettype wire

/* bench/testbench.sv */
// self-checking bench for edge_pixel_graph_builder: pixel items in, graph records out
// depends on epgb_pkg and the edge_pixel_graph_builder rtl; records are predicted in-bench
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    epgb_pkg::kind_t kind;
    bit [9:0]    row;
    bit [9:0]    col;
    bit [7:0]    intensity;
    bit [10:0]   gx;
    bit [10:0]   gy;
    bit [19:0]   efrom;
    bit [19:0]   eto;
    bit [20:0]   ntot;
    bit [23:0]   etot;
    bit [15:0]   label;
    bit          last;
  } graph_rec_t;

  typedef struct {
    bit [7:0]  grey;
    bit [7:0]  edge_v;
    bit        typed;
    bit [20:0] nodes;
    bit [23:0] edges;
  } pixel_row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [15:0] in_tdata = 0;  // grey_pixel, edge_pixel
  logic out_tvalid;
  logic out_tready = 0;
  // row, col, intensity, gx, gy, from, to, nodes, edges, label
  logic [epgb_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;  // record_kind
  logic out_tlast;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [4:0] cfg_paddr = 0;
  logic [31:0] cfg_pwdata = 0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  edge_pixel_graph_builder i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // predictor state
  bit [10:0] m_width = 1024, m_height = 1024;
  bit [7:0]  m_thresh = 25;
  bit        m_eight = 0;
  bit [15:0] m_label = 0;
  bit [7:0]  top_line [1024];
  bit [7:0]  mid_line [1024];
  bit [7:0]  edge_line [1024];
  bit [20:0] node_line [1024];
  bit        node_line_ok [1024];
  bit [7:0]  win [3][3];
  bit [20:0] left_num, upleft_num;
  bit        left_ok, upleft_ok;
  bit [7:0]  edge_dly;
  int        pos_row, pos_col;
  bit [20:0] node_cnt;
  bit [23:0] edge_cnt;

  graph_rec_t pending_recs[$];
  int  errors = 0;
  int  rx_count = 0;
  bit  calm = 0;
  longint cycles = 0;

  function automatic int clamp_dim(int v);
    return v < 3 ? 3 : (v > 1024 ? 1024 : v);
  endfunction

  function automatic graph_rec_t blank_rec();
    graph_rec_t r;
    r.kind = epgb_pkg::KIND_NODE; r.row = 0; r.col = 0; r.intensity = 0; r.gx = 0; r.gy = 0;
    r.efrom = 0; r.eto = 0; r.ntot = 0; r.etot = 0; r.label = 0; r.last = 0;
    return r;
  endfunction

  task automatic add_link(bit [20:0] other, bit [20:0] self);
    graph_rec_t r;
    r = blank_rec();
    r.kind = epgb_pkg::KIND_EDGE; r.efrom = other[19:0]; r.eto = self[19:0];
    pending_recs.push_back(r);
    r.efrom = self[19:0]; r.eto = other[19:0];
    pending_recs.push_back(r);
    edge_cnt = edge_cnt + 24'd2;
  endtask

  task automatic predict_pixel(bit [7:0] g, bit [7:0] e);
    int w, h, r, c, n0, gxs, gys;
    bit [7:0] gt, gm, eu, ce;
    bit up_ok, is_node;
    bit [20:0] up_num, id;
    graph_rec_t rec;
    w = clamp_dim(int'(m_width)); h = clamp_dim(int'(m_height));
    r = pos_row; c = pos_col; n0 = pending_recs.size();
    gt = top_line[c]; gm = mid_line[c]; eu = edge_line[c]; ce = edge_dly;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = gt; win[1][2] = gm; win[2][2] = g;
    top_line[c] = gm; mid_line[c] = g; edge_line[c] = e; edge_dly = eu;
    if (r >= 2 && c >= 2 && r <= h - 1 && c <= w - 1) begin
      up_ok = node_line_ok[c-1];
      up_num = node_line[c-1];
      is_node = ce > m_thresh;
      id = node_cnt;
      if (is_node) begin
        gxs = win[0][0] + win[1][0] + win[2][0] - win[0][2] - win[1][2] - win[2][2];
        gys = win[0][0] + win[0][1] + win[0][2] - win[2][0] - win[2][1] - win[2][2];
        rec = blank_rec();
        rec.row = 10'(r - 1); rec.col = 10'(c - 1); rec.intensity = win[1][1];
        rec.gx = gxs[10:0]; rec.gy = gys[10:0];
        pending_recs.push_back(rec);
        if (c - 1 >= 2 && left_ok) add_link(left_num, id);
        if (r - 1 >= 2 && up_ok) add_link(up_num, id);
        if (m_eight) begin
          if (r - 1 >= 2 && c - 1 >= 2 && upleft_ok) add_link(upleft_num, id);
          if (r - 1 >= 2 && c <= w - 2 && node_line_ok[c]) add_link(node_line[c], id);
        end
        node_cnt = node_cnt + 21'd1;
      end
      upleft_num = up_num; upleft_ok = up_ok;
      node_line[c-1] = id; node_line_ok[c-1] = is_node;
      left_num = id; left_ok = is_node;
    end
    if (c + 1 >= w) begin
      pos_col = 0;
      if (r + 1 >= h) begin
        rec = blank_rec();
        rec.kind = epgb_pkg::KIND_SUMMARY; rec.ntot = node_cnt; rec.etot = edge_cnt;
        rec.label = m_label;
        pending_recs.push_back(rec);
        pos_row = 0; node_cnt = 0; edge_cnt = 0;
      end else begin
        pos_row = r + 1;
      end
    end else begin
      pos_col = c + 1;
    end
    if (pending_recs.size() > n0) pending_recs[pending_recs.size()-1].last = 1;
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    case (idx)
      epgb_pkg::REG_WIDTH:  m_width = val[10:0];
      epgb_pkg::REG_HEIGHT: m_height = val[10:0];
      epgb_pkg::REG_THRESH: m_thresh = val[7:0];
      epgb_pkg::REG_MODE:   m_eight = val[0];
      epgb_pkg::REG_LABEL:  m_label = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_frame(int w, int h, int th, bit eight, int lbl);
    wait (pending_recs.size() == 0);
    repeat (12) @(posedge clk);
    cfg_write(epgb_pkg::REG_WIDTH, w);
    cfg_write(epgb_pkg::REG_HEIGHT, h);
    cfg_write(epgb_pkg::REG_THRESH, th);
    cfg_write(epgb_pkg::REG_MODE, 32'(eight));
    cfg_write(epgb_pkg::REG_LABEL, lbl);
  endtask

  task automatic send_pixel(bit [7:0] g, bit [7:0] e);
    while (!calm && $urandom_range(99) < 37) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {e, g};
    do @(posedge clk); while (!in_tready);
    predict_pixel(g, e);
  endtask

  task automatic send_frame(int w, int h, bit eight);
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(9) == 0) begin
        send_pixel(8'($urandom_range(0, 1) * 255), 8'($urandom_range(0, 1) * 255));
      end else if (eight && $urandom_range(1) == 0) begin
        send_pixel(8'($urandom), 8'd255);
      end else begin
        send_pixel(8'($urandom), 8'($urandom));
      end
    end
    in_tvalid <= 0;
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s expected %0d actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // receiver with random stalls and one long hold-off
  initial begin
    int hold;
    graph_rec_t e;
    hold = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (out_tvalid && out_tready) begin
        rx_count++;
        if (pending_recs.size() == 0) begin
          $error("record with no expectation, kind %0d", out_tuser);
          errors++;
        end else begin
          e = pending_recs.pop_front();
          check_field("record_kind", e.kind, out_tuser);
          check_field("pixel_row", e.row, out_tdata[9:0]);
          check_field("pixel_col", e.col, out_tdata[19:10]);
          check_field("intensity", e.intensity, out_tdata[27:20]);
          check_field("grad_x", $signed(e.gx), $signed(out_tdata[38:28]));
          check_field("grad_y", $signed(e.gy), $signed(out_tdata[49:39]));
          check_field("edge_from", e.efrom, out_tdata[69:50]);
          check_field("edge_to", e.eto, out_tdata[89:70]);
          check_field("node_total", e.ntot, out_tdata[110:90]);
          check_field("edge_total", e.etot, out_tdata[134:111]);
          check_field("label_out", e.label, out_tdata[150:135]);
          check_field("last", e.last, out_tlast);
        end
      end
      if (rx_count >= 150 && hold == 0 && in_tvalid) hold = 400;
      if (hold > 1) begin
        hold--;
        out_tready <= 0;
      end else begin
        out_tready <= calm || $urandom_range(99) >= 37;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (cycles > 1500000) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  pixel_row_t stim_table [$];

  initial begin
    pixel_row_t p;
    int sent;
    repeat (11) @(posedge clk);
    rst_n <= 1;

    // 3x3 frame, every edge strong: one node at the center, no links
    for (int i = 0; i < 9; i++) begin
      p.grey = (i % 2) ? 8'hFF : 8'h00; p.edge_v = 8'hFF;
      p.typed = (i == 8); p.nodes = 1; p.edges = 0;
      stim_table.push_back(p);
    end
    // 4x4 frame, eight neighbours, threshold max minus one: four nodes, twelve directed edges
    for (int i = 0; i < 16; i++) begin
      p.grey = 8'($urandom); p.edge_v = 8'hFF;
      p.typed = (i == 15); p.nodes = 4; p.edges = 12;
      stim_table.push_back(p);
    end
    for (int i = 0; i < stim_table.size(); i++) begin
      if (i == 0) set_frame(3, 3, 0, 0, 0);
      if (i == 9) set_frame(4, 4, 254, 1, 16'hFFFF);
      send_pixel(stim_table[i].grey, stim_table[i].edge_v);
      if (stim_table[i].typed) begin
        graph_rec_t t;
        t = blank_rec();
        t.kind = epgb_pkg::KIND_SUMMARY; t.ntot = stim_table[i].nodes;
        t.etot = stim_table[i].edges;
        t.label = m_label; t.last = 1;
        pending_recs[pending_recs.size()-1] = t;
      end
      if (i == 8 || i == 24) in_tvalid <= 0;
    end

    // random frames, mostly small
    sent = 0;
    while (sent < 420) begin
      int w, h, th;
      bit eight;
      w = $urandom_range(3, 10); h = $urandom_range(3, 10);
      th = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, 255);
      eight = $urandom_range(1);
      calm = (sent > 200 && sent < 300);
      set_frame(w, h, th, eight, $urandom_range(0, 65535));
      send_frame(w, h, eight);
      sent += w * h;
    end
    calm = 0;

    // extremes: out-of-range sizes clamp to the smallest frame
    set_frame(1, 1, 100, 1, 16'h0001);
    send_frame(3, 3, 1);
    set_frame(0, 2, 255, 0, 16'h8000);
    send_frame(3, 3, 0);

    wait (pending_recs.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_recs.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
